// ----- hw/rtl/rti_pkg.sv -----
`timescale 1ns / 1ps
package rti_pkg;

  // Coordinate format: signed, CW bits per component
  localparam int CW = 16;
  localparam int IW = 48;                // packed field width
  localparam int EW = CW + 1;            // edge and offset vectors
  localparam int PW = CW + EW + 1;       // P = D x E2
  localparam int QW = 2 * EW + 1;        // Q = T x E1
  localparam int MW = EW + QW;           // dot product terms
  localparam int SW = MW + 2;            // det, t, v, w
  localparam int RW = SW + 1;            // divider remainder
  localparam int EPSW = 20;              // det_epsilon width
  localparam int QBITS = 32;             // quotient bits
  localparam int FRACS = 16;             // quotient scaling
  localparam int BVW = 17;               // barycentric width

  localparam logic [EPSW-1:0] EPS_RESET = EPSW'(2);

  typedef enum logic [1:0] {
    RSN_HIT      = 2'd0,
    RSN_PARALLEL = 2'd1,
    RSN_BEHIND   = 2'd2,
    RSN_OUTSIDE  = 2'd3
  } rsn_t;

  // One slot of the divider pipeline; lane 0 is t, lane 1 is v, lane 2 is w
  typedef struct packed {
    logic                        valid;
    logic                        hit;
    rsn_t                        reason;
    logic                        sat;
    logic [RW-1:0]               det;
    logic [2:0][RW-1:0]          rem;
    logic [2:0][QBITS-1:0]       num;
    logic [2:0][QBITS-1:0]       quo;
  } div_t;

endpackage

// ----- hw/rtl/rti_geom.sv -----
`timescale 1ns / 1ps
module rti_geom (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [rti_pkg::IW-1:0] ray_origin,
  input  logic [rti_pkg::IW-1:0] ray_direction,
  input  logic [rti_pkg::IW-1:0] vertex_a,
  input  logic [rti_pkg::IW-1:0] vertex_b,
  input  logic [rti_pkg::IW-1:0] vertex_c,
  input  logic [rti_pkg::EPSW-1:0] det_eps,
  output rti_pkg::div_t          div_out
);
  import rti_pkg::*;

  logic [4:0] vld_r;

  logic signed [2:0][CW-1:0] d1_r, d2_r, d3_r;
  logic signed [2:0][EW-1:0] e1_1_r, e2_1_r, t_1_r;
  logic signed [2:0][EW-1:0] e1_2_r, e2_2_r, t_2_r;
  logic signed [2:0][EW-1:0] e1_3_r, e2_3_r, t_3_r;
  logic signed [2:0][1:0][PW-2:0] pp_r;
  logic signed [2:0][1:0][QW-2:0] qp_r;
  logic signed [2:0][PW-1:0] p_r;
  logic signed [2:0][QW-1:0] q_r;
  logic signed [2:0][MW-1:0] mdet_r, mt_r, mv_r, mw_r;
  logic signed [SW-1:0] det_r, t_r, v_r, w_r;
  div_t div_r;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Stage 1: unpack, form edges and origin offset
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]   <= ray_direction[k*CW +: CW];
        e1_1_r[k] <= EW'($signed(vertex_b[k*CW +: CW])) - EW'($signed(vertex_a[k*CW +: CW]));
        e2_1_r[k] <= EW'($signed(vertex_c[k*CW +: CW])) - EW'($signed(vertex_a[k*CW +: CW]));
        t_1_r[k]  <= EW'($signed(ray_origin[k*CW +: CW])) - EW'($signed(vertex_a[k*CW +: CW]));
      end
    end
  end

  // Stage 2: cross product terms of P = D x E2 and Q = T x E1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pp_r[k][0] <= $signed(d1_r[(k+1)%3]) * $signed(e2_1_r[(k+2)%3]);
        pp_r[k][1] <= $signed(d1_r[(k+2)%3]) * $signed(e2_1_r[(k+1)%3]);
        qp_r[k][0] <= $signed(t_1_r[(k+1)%3]) * $signed(e1_1_r[(k+2)%3]);
        qp_r[k][1] <= $signed(t_1_r[(k+2)%3]) * $signed(e1_1_r[(k+1)%3]);
      end
      d2_r <= d1_r;
      e1_2_r <= e1_1_r;
      e2_2_r <= e2_1_r;
      t_2_r <= t_1_r;
    end
  end

  // Stage 3: finish the cross products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= PW'($signed(pp_r[k][0])) - PW'($signed(pp_r[k][1]));
        q_r[k] <= QW'($signed(qp_r[k][0])) - QW'($signed(qp_r[k][1]));
      end
      d3_r <= d2_r;
      e1_3_r <= e1_2_r;
      e2_3_r <= e2_2_r;
      t_3_r <= t_2_r;
    end
  end

  // Stage 4: dot product terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mdet_r[k] <= MW'($signed(e1_3_r[k]) * $signed(p_r[k]));
        mt_r[k]   <= MW'($signed(e2_3_r[k]) * $signed(q_r[k]));
        mv_r[k]   <= MW'($signed(t_3_r[k]) * $signed(p_r[k]));
        mw_r[k]   <= MW'($signed(d3_r[k]) * $signed(q_r[k]));
      end
    end
  end

  // Stage 5: sum the dot products
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= SW'($signed(mdet_r[0])) + SW'($signed(mdet_r[1])) + SW'($signed(mdet_r[2]));
      t_r   <= SW'($signed(mt_r[0])) + SW'($signed(mt_r[1])) + SW'($signed(mt_r[2]));
      v_r   <= SW'($signed(mv_r[0])) + SW'($signed(mv_r[1])) + SW'($signed(mv_r[2]));
      w_r   <= SW'($signed(mw_r[0])) + SW'($signed(mw_r[1])) + SW'($signed(mw_r[2]));
    end
  end

  // Stage 6: fix the sign, classify, seed the divider
  logic signed [SW-1:0] dn, tn, vn, wn, vw;
  logic                 det_pos;
  rsn_t                 rsn;
  div_t                 div_nxt;

  always_comb begin
    det_pos = !det_r[SW-1] && (det_r != '0);
    dn = det_pos ? det_r : -det_r;
    tn = det_pos ? t_r : -t_r;
    vn = det_pos ? v_r : -v_r;
    wn = det_pos ? w_r : -w_r;
    vw = vn + wn;
    if ((dn == '0) || (dn < $signed({{(SW-EPSW){1'b0}}, det_eps}))) begin
      rsn = RSN_PARALLEL;
    end else if (tn[SW-1]) begin
      rsn = RSN_BEHIND;
    end else if (vn[SW-1] || (vn > dn)) begin
      rsn = RSN_OUTSIDE;
    end else if (wn[SW-1] || (vw > dn)) begin
      rsn = RSN_OUTSIDE;
    end else begin
      rsn = RSN_HIT;
    end

    div_nxt.valid  = vld_r[4];
    div_nxt.hit    = (rsn == RSN_HIT);
    div_nxt.reason = rsn;
    div_nxt.sat    = ($signed({1'b0, tn[SW-1:FRACS]}) >= dn);
    div_nxt.det    = RW'(dn);
    div_nxt.quo    = '0;
    div_nxt.rem    = '0;
    div_nxt.num    = '0;
    if (div_nxt.hit) begin
      if (!div_nxt.sat) begin
        div_nxt.rem[0] = RW'(tn[SW-1:FRACS]);
        div_nxt.num[0] = {tn[FRACS-1:0], {(QBITS-FRACS){1'b0}}};
      end
      div_nxt.rem[1] = RW'(vn[SW-1:FRACS]);
      div_nxt.num[1] = {vn[FRACS-1:0], {(QBITS-FRACS){1'b0}}};
      div_nxt.rem[2] = RW'(wn[SW-1:FRACS]);
      div_nxt.num[2] = {wn[FRACS-1:0], {(QBITS-FRACS){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else if (en) begin
      div_r.valid <= div_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r.hit    <= div_nxt.hit;
      div_r.reason <= div_nxt.reason;
      div_r.sat    <= div_nxt.sat;
      div_r.det    <= div_nxt.det;
      div_r.rem    <= div_nxt.rem;
      div_r.num    <= div_nxt.num;
      div_r.quo    <= div_nxt.quo;
    end
  end

  assign div_out = div_r;

endmodule

// ----- hw/rtl/rti_div_stage.sv -----
`timescale 1ns / 1ps
module rti_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  rti_pkg::div_t div_in,
  output rti_pkg::div_t div_out
);
  import rti_pkg::*;

  div_t          div_r;
  logic [RW-1:0] shf;
  logic [RW-1:0] rem_nxt [3];
  logic          bit_nxt [3];

  // Shift in one numerator bit per lane, subtract det when it fits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shf = {div_in.rem[k][RW-2:0], div_in.num[k][QBITS-1]};
      bit_nxt[k] = (shf >= div_in.det);
      rem_nxt[k] = bit_nxt[k] ? shf - div_in.det : shf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else if (en) begin
      div_r.valid <= div_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r.hit    <= div_in.hit;
      div_r.reason <= div_in.reason;
      div_r.sat    <= div_in.sat;
      div_r.det    <= div_in.det;
      for (int k = 0; k < 3; k++) begin
        div_r.rem[k] <= rem_nxt[k];
        div_r.num[k] <= {div_in.num[k][QBITS-2:0], 1'b0};
        div_r.quo[k] <= {div_in.quo[k][QBITS-2:0], bit_nxt[k]};
      end
    end
  end

  assign div_out = div_r;

endmodule

// ----- hw/rtl/ray_triangle_intersect.sv -----
`timescale 1ns / 1ps
// Moller-Trumbore ray/triangle test, one test per clock unless the receiver stalls.
// Input channel: in_valid/in_ready carry the ray origin and direction and the
// three vertices, each packed as signed x, y, z components, x in the low bits.
// Result channel: out_valid/out_ready carry the hit flag, the miss reason and,
// on a hit, the distance (Q16.16, saturated) and the v and w weights (Q1.16).
// Configuration: cfg_valid/cfg_ready write det_epsilon; cfg_ready is always
// high. Write it only while no test is in flight.
// Pipeline: six register stages of vector arithmetic (the first loaded by the
// input transfer), one quotient bit per stage over 32 divider stages, and the
// output register. Throughput: one test per cycle unless the receiver stalls,
// set by the fully pipelined datapath.
// Reset clears every valid bit and loads det_epsilon with 2.
// When the receiver stalls, the whole pipeline holds; in_ready drops only
// while a result waits and out_ready is low, so nothing is lost or repeated.
module ray_triangle_intersect (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rti_pkg::IW-1:0]   in_ray_origin,
  input  logic [rti_pkg::IW-1:0]   in_ray_direction,
  input  logic [rti_pkg::IW-1:0]   in_vertex_a,
  input  logic [rti_pkg::IW-1:0]   in_vertex_b,
  input  logic [rti_pkg::IW-1:0]   in_vertex_c,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_hit,
  output logic [1:0]               out_miss_reason,
  output logic [31:0]              out_distance,
  output logic [16:0]              out_bary_v,
  output logic [16:0]              out_bary_w,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rti_pkg::EPSW-1:0] cfg_det_epsilon
);
  import rti_pkg::*;

  logic            en;
  logic [EPSW-1:0] det_eps_r;
  div_t            div_pipe [QBITS+1];

  logic            out_valid_r;
  logic            out_is_hit_r;
  rsn_t            out_reason_r;
  logic [31:0]     out_distance_r;
  logic [16:0]     out_bary_v_r;
  logic [16:0]     out_bary_w_r;

  // Advance everything unless a result waits untaken
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Hold the epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      det_eps_r <= cfg_det_epsilon;
    end
  end

  rti_geom u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .ray_origin    (in_ray_origin),
    .ray_direction (in_ray_direction),
    .vertex_a      (in_vertex_a),
    .vertex_b      (in_vertex_b),
    .vertex_c      (in_vertex_c),
    .det_eps       (det_eps_r),
    .div_out       (div_pipe[0])
  );

  // One quotient bit per stage
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    rti_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .div_in  (div_pipe[i]),
      .div_out (div_pipe[i+1])
    );
  end

  // Output register: zero the payload on a miss, saturate far hits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_pipe[QBITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_is_hit_r   <= div_pipe[QBITS].hit;
      out_reason_r   <= div_pipe[QBITS].reason;
      out_distance_r <= !div_pipe[QBITS].hit ? '0 :
                        div_pipe[QBITS].sat ? '1 : div_pipe[QBITS].quo[0];
      out_bary_v_r   <= div_pipe[QBITS].hit ? div_pipe[QBITS].quo[1][BVW-1:0] : '0;
      out_bary_w_r   <= div_pipe[QBITS].hit ? div_pipe[QBITS].quo[2][BVW-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_hit      = out_is_hit_r;
  assign out_miss_reason = out_reason_r;
  assign out_distance    = out_distance_r;
  assign out_bary_v      = out_bary_v_r;
  assign out_bary_w      = out_bary_w_r;

`ifndef NO_ASSERTIONS
  a_hit_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_hit == (out_miss_reason == RSN_HIT)))
    else $error("hit flag disagrees with miss reason");
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_hit) |-> (out_distance == '0 && out_bary_v == '0
      && out_bary_w == '0))
    else $error("miss carries nonzero payload");
  a_bary_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_hit) |-> (out_bary_v <= 17'd65536 && out_bary_w <= 17'd65536))
    else $error("barycentric weight out of range");
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
